// ===== rtl/mtep_pkg.sv =====
// Shared types, constants and helper functions of the MIDI track event parser.
`timescale 1ns / 1ps
package mtep_pkg;

	localparam int TRACKS_DEF = 16;
	localparam int TRACK_W = 4;
	localparam int DELTA_W = 28;

	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW = 2;
	localparam int OQ_CW = 3;

	localparam logic [7:0] ST_META = 8'hFF;
	localparam logic [7:0] ST_SYSEX = 8'hF0;
	localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
	localparam logic [3:0] HI_PROG = 4'hC;
	localparam logic [3:0] HI_CHPRESS = 4'hD;
	localparam logic [2:0] VL_MAX_BYTES = 3'd4;

	typedef enum logic [2:0] {
		PH_DELTA = 3'd0,
		PH_STATUS = 3'd1,
		PH_META = 3'd2,
		PH_LEN = 3'd3,
		PH_DATA = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		VL_MORE = 2'd0,
		VL_DONE = 2'd1,
		VL_OVER = 2'd2
	} vl_t;

	typedef struct packed {
		phase_t phase;
		logic [7:0] rstat;
		logic [DELTA_W-1:0] acc;
		logic [2:0] cnt;
		logic [DELTA_W-1:0] rem;
		logic [DELTA_W-1:0] delta;
	} ctx_t;

	typedef struct packed {
		logic [7:0] data;
		logic first;
		logic last;
		logic err;
	} res_item_t;

	typedef struct packed {
		logic [1:0] n;
		logic [DELTA_W-1:0] delta;
		res_item_t r0;
		res_item_t r1;
	} step_res_t;

	typedef struct packed {
		logic [7:0] data;
		logic [DELTA_W-1:0] delta;
		logic first;
		logic last;
		logic err;
		logic [TRACK_W-1:0] track;
	} out_item_t;

	function automatic res_item_t mk_item(logic [7:0] d, logic f, logic l, logic e);
		res_item_t r;
		r.data = d;
		r.first = f;
		r.last = l;
		r.err = e;
		return r;
	endfunction

	// Program change and channel pressure carry a single data byte.
	function automatic logic is_one_data(logic [7:0] st);
		return (st[7:4] == HI_PROG) || (st[7:4] == HI_CHPRESS);
	endfunction

endpackage

// ===== rtl/mtep_ctx_mem.sv =====
// Per-track parse context memory with valid bits and write-to-read forwarding.
`timescale 1ns / 1ps
module mtep_ctx_mem #(
	parameter int TRACKS = mtep_pkg::TRACKS_DEF,
	localparam int IDX_W = (TRACKS > 1) ? $clog2(TRACKS) : 1
) (
	input logic clk,
	input logic arst_n,
	input logic rd_en,
	input logic [IDX_W-1:0] rd_addr,
	output mtep_pkg::ctx_t rd_data,
	input logic wr_en,
	input logic [IDX_W-1:0] wr_addr,
	input mtep_pkg::ctx_t wr_data
);
	import mtep_pkg::*;

	ctx_t ctx_mem [TRACKS];
	ctx_t rd_data_q;
	logic rd_vld_q;
	logic [TRACKS-1:0] vld_q;
	logic same_entry;

	assign same_entry = wr_en && (wr_addr == rd_addr);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ctx_mem[wr_addr] <= wr_data;
		end
	end

	// A read that meets a write to the same entry returns the new context.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= same_entry ? wr_data : ctx_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr] || same_entry;
			end
		end
	end

	// An entry never written since reset reads as the cleared context.
	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== rtl/mtep_step.sv =====
// Next-context and result logic for one track byte.
`timescale 1ns / 1ps
module mtep_step (
	input mtep_pkg::ctx_t ctx,
	input logic [7:0] data_in,
	input logic start,
	output mtep_pkg::ctx_t nxt,
	output mtep_pkg::step_res_t res
);
	import mtep_pkg::*;

	ctx_t cur;
	logic [DELTA_W-1:0] acc_n;
	logic [DELTA_W-1:0] rem_n;
	logic [2:0] cnt_n;
	vl_t vl;
	logic err;
	logic rs_one;

	always_comb begin
		cur = start ? '0 : ctx;
		nxt = cur;
		res = '0;
		res.delta = cur.delta;
		err = 1'b0;
		acc_n = {cur.acc[DELTA_W-8:0], data_in[6:0]};
		cnt_n = cur.cnt + 3'd1;
		rem_n = cur.rem - {{(DELTA_W-1){1'b0}}, 1'b1};
		rs_one = is_one_data(cur.rstat);
		if (!data_in[7]) begin
			vl = VL_DONE;
		end else if (cnt_n >= VL_MAX_BYTES) begin
			vl = VL_OVER;
		end else begin
			vl = VL_MORE;
		end

		unique case (cur.phase)
			PH_STATUS: begin
				if (data_in == ST_META) begin
					res.n = 2'd1;
					res.r0 = mk_item(data_in, 1'b1, 1'b0, 1'b0);
					nxt.phase = PH_META;
				end else if (data_in == ST_SYSEX || data_in == ST_SYSEX_ESC) begin
					nxt.rstat = '0;
					res.n = 2'd1;
					res.r0 = mk_item(data_in, 1'b1, 1'b0, 1'b0);
					nxt.acc = '0;
					nxt.cnt = '0;
					nxt.phase = PH_LEN;
				end else if (data_in[7]) begin
					if (data_in > ST_SYSEX) begin
						err = 1'b1;
					end else begin
						nxt.rstat = data_in;
						nxt.rem = is_one_data(data_in) ? DELTA_W'(1) : DELTA_W'(2);
						res.n = 2'd1;
						res.r0 = mk_item(data_in, 1'b1, 1'b0, 1'b0);
						nxt.phase = PH_DATA;
					end
				end else if (cur.rstat[7]) begin
					// Running status: replay the stored status ahead of the data byte.
					res.n = 2'd2;
					res.r0 = mk_item(cur.rstat, 1'b1, 1'b0, 1'b0);
					res.r1 = mk_item(data_in, 1'b0, rs_one, 1'b0);
					nxt.rem = rs_one ? '0 : DELTA_W'(1);
					if (rs_one) begin
						nxt.phase = PH_DELTA;
						nxt.acc = '0;
						nxt.cnt = '0;
					end else begin
						nxt.phase = PH_DATA;
					end
				end else begin
					err = 1'b1;
				end
			end
			PH_META: begin
				res.n = 2'd1;
				res.r0 = mk_item(data_in, 1'b0, 1'b0, 1'b0);
				nxt.acc = '0;
				nxt.cnt = '0;
				nxt.phase = PH_LEN;
			end
			PH_LEN: begin
				nxt.acc = acc_n;
				nxt.cnt = cnt_n;
				if (vl == VL_OVER) begin
					err = 1'b1;
				end else if (vl == VL_MORE) begin
					res.n = 2'd1;
					res.r0 = mk_item(data_in, 1'b0, 1'b0, 1'b0);
				end else begin
					nxt.rem = acc_n;
					nxt.acc = '0;
					nxt.cnt = '0;
					res.n = 2'd1;
					res.r0 = mk_item(data_in, 1'b0, acc_n == '0, 1'b0);
					nxt.phase = (acc_n == '0) ? PH_DELTA : PH_DATA;
				end
			end
			PH_DATA: begin
				nxt.rem = rem_n;
				res.n = 2'd1;
				res.r0 = mk_item(data_in, 1'b0, rem_n == '0, 1'b0);
				if (rem_n == '0) begin
					nxt.phase = PH_DELTA;
					nxt.acc = '0;
					nxt.cnt = '0;
				end
			end
			default: begin
				// Delta time phase; unused codes behave the same way.
				nxt.acc = acc_n;
				nxt.cnt = cnt_n;
				if (vl == VL_OVER) begin
					err = 1'b1;
				end else if (vl == VL_DONE) begin
					nxt.delta = acc_n;
					nxt.acc = '0;
					nxt.cnt = '0;
					nxt.phase = PH_STATUS;
				end else begin
					nxt.phase = PH_DELTA;
				end
			end
		endcase

		if (err) begin
			nxt.phase = PH_DELTA;
			nxt.acc = '0;
			nxt.cnt = '0;
			nxt.rem = '0;
			res.n = 2'd1;
			res.r0 = mk_item(data_in, 1'b1, 1'b1, 1'b1);
			res.r1 = '0;
		end
	end

endmodule

// ===== rtl/mtep_out_fifo.sv =====
// Small result queue that takes up to two entries per cycle and gives one.
`timescale 1ns / 1ps
module mtep_out_fifo (
	input logic clk,
	input logic arst_n,
	input logic [1:0] push_n,
	input mtep_pkg::out_item_t push0,
	input mtep_pkg::out_item_t push1,
	input logic pop,
	output mtep_pkg::out_item_t head,
	output logic not_empty,
	output logic room
);
	import mtep_pkg::*;

	out_item_t q_mem [OQ_DEPTH];
	logic [OQ_AW-1:0] wp_q;
	logic [OQ_AW-1:0] rp_q;
	logic [OQ_CW-1:0] cnt_q;
	logic do_pop;

	assign do_pop = pop && (cnt_q != '0);

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			q_mem[wp_q] <= push0;
		end
		if (push_n == 2'd2) begin
			q_mem[wp_q + OQ_AW'(1)] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + OQ_AW'(push_n);
			rp_q <= rp_q + OQ_AW'(do_pop);
			cnt_q <= cnt_q + OQ_CW'(push_n) - OQ_CW'(do_pop);
		end
	end

	assign head = q_mem[rp_q];
	assign not_empty = (cnt_q != '0);
	assign room = (cnt_q <= OQ_CW'(OQ_DEPTH - 2));

endmodule

// ===== rtl/midi_track_event_parser_core.sv =====
// Top level of the per-track MIDI track event parser.
`timescale 1ns / 1ps
// A byte accepted at the input is registered into stage 1, which writes its results into the result queue.
// Throughput: one byte per cycle while the result queue has room, set by the single read and single
// write port of the context memory; a running-status byte yields two results, so the output side
// then paces the input. Reset (arst_n low) clears the memory valid bits, the pipeline and the
// result queue at once; every track then reads as a cleared context and no clearing pass is needed.
module midi_track_event_parser_core #(
	parameter int TRACKS = mtep_pkg::TRACKS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [mtep_pkg::TRACK_W-1:0] track_index,
	input logic [7:0] data_byte,
	input logic track_start,
	output logic out_valid,
	input logic out_ready,
	output logic [7:0] event_byte,
	output logic [mtep_pkg::DELTA_W-1:0] delta_ticks,
	output logic first_of_event,
	output logic last_of_event,
	output logic parse_error,
	output logic [mtep_pkg::TRACK_W-1:0] event_track
);
	import mtep_pkg::*;

	localparam int IDX_W = (TRACKS > 1) ? $clog2(TRACKS) : 1;

	// Stage 0 issues the context read; stage 1 sees the read data, computes the
	// new context, writes it back and pushes its results into the queue.
	logic in_accept;
	logic in_range;
	logic valid_s1;
	logic inr_s1;
	logic start_s1;
	logic [7:0] byte_s1;
	logic [TRACK_W-1:0] track_s1;
	logic fire_s1;
	logic q_room;
	logic q_not_empty;
	ctx_t ctx_rd;
	ctx_t ctx_nxt;
	step_res_t res;
	out_item_t push0;
	out_item_t push1;
	out_item_t head;
	logic [1:0] push_n;
	logic wr_en;

	// Bytes for tracks beyond the configured count are taken and dropped.
	assign in_range = (32'(track_index) < TRACKS);
	assign fire_s1 = valid_s1 && q_room;
	assign in_ready = !valid_s1 || fire_s1;
	assign in_accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			inr_s1 <= in_range;
			start_s1 <= track_start;
			byte_s1 <= data_byte;
			track_s1 <= track_index;
		end
	end

	// The memory forwards a write that lands on the entry read in the same cycle,
	// which covers two back-to-back bytes of one track.
	assign wr_en = fire_s1 && inr_s1;

	mtep_ctx_mem #(
		.TRACKS(TRACKS)
	) u_ctx_mem (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(in_accept && in_range),
		.rd_addr(IDX_W'(track_index)),
		.rd_data(ctx_rd),
		.wr_en(wr_en),
		.wr_addr(IDX_W'(track_s1)),
		.wr_data(ctx_nxt)
	);

	mtep_step u_step (
		.ctx(ctx_rd),
		.data_in(byte_s1),
		.start(start_s1),
		.nxt(ctx_nxt),
		.res(res)
	);

	always_comb begin
		push0.data = res.r0.data;
		push0.delta = res.delta;
		push0.first = res.r0.first;
		push0.last = res.r0.last;
		push0.err = res.r0.err;
		push0.track = track_s1;
		push1.data = res.r1.data;
		push1.delta = res.delta;
		push1.first = res.r1.first;
		push1.last = res.r1.last;
		push1.err = res.r1.err;
		push1.track = track_s1;
	end

	assign push_n = wr_en ? res.n : 2'd0;

	// The queue keeps two free slots before a byte may leave stage 1, so a
	// finished result can wait on the output while new bytes keep coming.
	mtep_out_fifo u_out_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_n(push_n),
		.push0(push0),
		.push1(push1),
		.pop(out_ready),
		.head(head),
		.not_empty(q_not_empty),
		.room(q_room)
	);

	assign out_valid = q_not_empty;
	assign event_byte = head.data;
	assign delta_ticks = head.delta;
	assign first_of_event = head.first;
	assign last_of_event = head.last;
	assign parse_error = head.err;
	assign event_track = head.track;

endmodule

// ===== rtl/mtep_checker.sv =====
// Port-level assertions for the MIDI track event parser, bound to the top level.
`timescale 1ns / 1ps
module mtep_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic [mtep_pkg::TRACK_W-1:0] track_index,
	input logic [7:0] data_byte,
	input logic track_start,
	input logic out_valid,
	input logic out_ready,
	input logic [7:0] event_byte,
	input logic [mtep_pkg::DELTA_W-1:0] delta_ticks,
	input logic first_of_event,
	input logic last_of_event,
	input logic parse_error,
	input logic [mtep_pkg::TRACK_W-1:0] event_track
);
	import mtep_pkg::*;

	// An error result is always a complete one-byte event.
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && parse_error |-> first_of_event && last_of_event)
		else $error("error transaction is not a single-byte event");

	// A good event always opens with a status byte.
	a_first_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && first_of_event && !parse_error |-> event_byte[7])
		else $error("event opens without a status byte");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result transaction withdrawn before acceptance");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(event_byte) && $stable(delta_ticks)
			&& $stable(event_track) && $stable(parse_error))
		else $error("stalled result transaction changed");

	// A waiting input transaction keeps its payload until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(track_index) && $stable(data_byte)
			&& $stable(track_start))
		else $error("input transaction changed before acceptance");

endmodule

bind midi_track_event_parser_core mtep_checker u_mtep_checker (.*);

// ===== sim/midi_track_event_parser_core_test.sv =====
// Self-checking testbench for the per-track MIDI track event parser core.
`timescale 1ns / 1ps
module midi_track_event_parser_core_test;
	import mtep_pkg::*;

	localparam int NUM_TRACKS = TRACKS_DEF;
	localparam int RANDOM_ITEMS = 1100;
	localparam int SCRIPT_DEPTH = 32;
	// Receiver hold-off and sender drain points, counted in random transactions, and the hold-off length.
	localparam int HOLD_AT = 300;
	localparam int LONG_HOLD = 200;
	localparam int DRAIN_AT = 700;
	// The longest stretch without a transaction in a correct run is about the long
	// hold-off; the limit is that stretch taken about ten times.
	localparam int WATCHDOG_LIMIT = 2000;
	// The block has a four-entry result queue.
	localparam int TAIL_CYCLES = 16;
	localparam int MAX_REPORTS = 10;
	localparam int DATA_MAX = 127;

	localparam logic [7:0] VL_CONT = 8'h80;
	localparam logic [7:0] CHANNEL_LO = 8'h80;
	localparam logic [7:0] CHANNEL_HI = 8'hEF;
	localparam logic [7:0] BAD_STATUS_LO = 8'hF1;
	localparam logic [7:0] BAD_STATUS_HI = 8'hFE;

	// How a row of the directed table is checked: against the predictor, or
	// against a result typed into the row, or as a byte that must give nothing.
	typedef enum logic [1:0] {
		ROW_CHECKED = 2'd0,
		ROW_TYPED = 2'd1,
		ROW_SILENT = 2'd2
	} row_kind_t;

	typedef struct packed {
		logic [TRACK_W-1:0] trk;
		logic [7:0] b;
		logic start;
		row_kind_t kind;
		logic [7:0] want_byte;
		logic [DELTA_W-1:0] want_delta;
		logic want_first;
		logic want_last;
		logic want_err;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 24;

	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		// Note-on with an explicit status on track 0, straight after reset.
		'{4'd0, 8'h00, 1'b0, ROW_SILENT, 8'h00, 28'd0, 1'b0, 1'b0, 1'b0},
		'{4'd0, 8'h90, 1'b0, ROW_TYPED, 8'h90, 28'd0, 1'b1, 1'b0, 1'b0},
		'{4'd0, 8'h3C, 1'b0, ROW_CHECKED, 8'h00, 28'd0, 1'b0, 1'b0, 1'b0},
		'{4'd0, 8'h7F, 1'b0, ROW_CHECKED, 8'h00, 28'd0, 1'b0, 1'b0, 1'b0},
		// Running status: the stored status comes out ahead of the data byte.
		'{4'd0, 8'h00, 1'b0, ROW_SILENT, 8'h00, 28'd0, 1'b0, 1'b0, 1'b0},
		'{4'd0, 8'h40, 1'b0, ROW_CHECKED, 8'h00, 28'd0, 1'b0, 1'b0, 1'b0},
		'{4'd0, 8'h00, 1'b0, ROW_CHECKED, 8'h00, 28'd0, 1'b0, 1'b0, 1'b0},
		// Largest delta time on the highest track, then an empty meta event.
		'{4'd15, 8'hFF, 1'b0, ROW_SILENT, 8'h00, 28'd0, 1'b0, 1'b0, 1'b0},
		'{4'd15, 8'hFF, 1'b0, ROW_SILENT, 8'h00, 28'd0, 1'b0, 1'b0, 1'b0},
		'{4'd15, 8'hFF, 1'b0, ROW_SILENT, 8'h00, 28'd0, 1'b0, 1'b0, 1'b0},
		'{4'd15, 8'h7F, 1'b0, ROW_SILENT, 8'h00, 28'd0, 1'b0, 1'b0, 1'b0},
		'{4'd15, ST_META, 1'b0, ROW_TYPED, ST_META, 28'h0FFFFFFF, 1'b1, 1'b0, 1'b0},
		'{4'd15, 8'h51, 1'b0, ROW_CHECKED, 8'h00, 28'd0, 1'b0, 1'b0, 1'b0},
		'{4'd15, 8'h00, 1'b0, ROW_TYPED, 8'h00, 28'h0FFFFFFF, 1'b0, 1'b1, 1'b0},
		// Undefined system status byte.
		'{4'd15, 8'h00, 1'b0, ROW_SILENT, 8'h00, 28'd0, 1'b0, 1'b0, 1'b0},
		'{4'd15, 8'hF5, 1'b0, ROW_TYPED, 8'hF5, 28'd0, 1'b1, 1'b1, 1'b1},
		// Data byte on a track that never saw a status byte.
		'{4'd2, 8'h00, 1'b0, ROW_SILENT, 8'h00, 28'd0, 1'b0, 1'b0, 1'b0},
		'{4'd2, 8'h45, 1'b0, ROW_TYPED, 8'h45, 28'd0, 1'b1, 1'b1, 1'b1},
		// Delta time that still continues after four bytes.
		'{4'd3, 8'hFF, 1'b0, ROW_SILENT, 8'h00, 28'd0, 1'b0, 1'b0, 1'b0},
		'{4'd3, 8'hFF, 1'b0, ROW_SILENT, 8'h00, 28'd0, 1'b0, 1'b0, 1'b0},
		'{4'd3, 8'hFF, 1'b0, ROW_SILENT, 8'h00, 28'd0, 1'b0, 1'b0, 1'b0},
		'{4'd3, 8'hFF, 1'b0, ROW_TYPED, 8'hFF, 28'd0, 1'b1, 1'b1, 1'b1},
		// A track start wipes the running status of track 0.
		'{4'd0, 8'h55, 1'b1, ROW_SILENT, 8'h00, 28'd0, 1'b0, 1'b0, 1'b0},
		'{4'd0, 8'h20, 1'b0, ROW_TYPED, 8'h20, 28'h55, 1'b1, 1'b1, 1'b1}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [TRACK_W-1:0] track_index = '0;
	logic [7:0] data_byte = 8'h00;
	logic track_start = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] event_byte;
	logic [DELTA_W-1:0] delta_ticks;
	logic first_of_event;
	logic last_of_event;
	logic parse_error;
	logic [TRACK_W-1:0] event_track;

	always #5 clk = ~clk;

	midi_track_event_parser_core #(
		.TRACKS(NUM_TRACKS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.track_index(track_index),
		.data_byte(data_byte),
		.track_start(track_start),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.event_byte(event_byte),
		.delta_ticks(delta_ticks),
		.first_of_event(first_of_event),
		.last_of_event(last_of_event),
		.parse_error(parse_error),
		.event_track(event_track)
	);

	// Parse context of every track, as the predictor sees it.
	phase_t trk_phase [NUM_TRACKS];
	logic [7:0] trk_rstat [NUM_TRACKS];
	logic [DELTA_W-1:0] trk_acc [NUM_TRACKS];
	logic [2:0] trk_cnt [NUM_TRACKS];
	logic [DELTA_W-1:0] trk_rem [NUM_TRACKS];
	logic [DELTA_W-1:0] trk_delta [NUM_TRACKS];

	out_item_t pending_event_bytes [$];

	int failure_count = 0;
	int bytes_sent = 0;
	int random_sent = 0;
	int results_seen = 0;
	int events_seen = 0;
	int errors_seen = 0;
	int long_holds = 0;
	int drain_pauses = 0;
	int channel_planned = 0;
	int running_planned = 0;
	int meta_planned = 0;
	int sysex_planned = 0;
	int idle_cycles = 0;
	int burst_left = 0;

	// Per-track byte scripts of the random part; bit 8 is the track start flag.
	logic [8:0] script_mem [NUM_TRACKS][SCRIPT_DEPTH];
	int script_len [NUM_TRACKS];
	int script_rd [NUM_TRACKS];
	logic [7:0] gen_rstat [NUM_TRACKS];
	bit track_seen [NUM_TRACKS];
	logic next_start;

	// Append one expected output byte to the tail of the queue.
	function automatic void expect_result(input out_item_t o);
		pending_event_bytes = {pending_event_bytes, o};
	endfunction

	function automatic logic has_one_data_byte(input logic [7:0] st);
		return st[7:5] == 3'b110;
	endfunction

	function automatic out_item_t event_item(input logic [7:0] b, input logic [DELTA_W-1:0] d,
			input logic f, input logic l, input logic e, input int t);
		out_item_t o;
		o.data = b;
		o.delta = d;
		o.first = f;
		o.last = l;
		o.err = e;
		o.track = t[TRACK_W-1:0];
		return o;
	endfunction

	function automatic void clear_track_ctx(input int t);
		trk_phase[t] = PH_DELTA;
		trk_rstat[t] = 8'h00;
		trk_acc[t] = '0;
		trk_cnt[t] = 3'd0;
		trk_rem[t] = '0;
		trk_delta[t] = '0;
	endfunction

	// Shift one byte of a variable-length value into the track's accumulator.
	function automatic vl_t shift_in_varlen(input int t, input logic [7:0] c);
		trk_acc[t] = {trk_acc[t][DELTA_W-8:0], c[6:0]};
		trk_cnt[t] = trk_cnt[t] + 3'd1;
		if (!c[7])
			return VL_DONE;
		return (trk_cnt[t] >= VL_MAX_BYTES) ? VL_OVER : VL_MORE;
	endfunction

	// Advance one track's context by one byte; returns how many result bytes it gives.
	function automatic int parse_track_byte(input int t, input logic [7:0] c,
			input logic start, output out_item_t r0, output out_item_t r1);
		logic [DELTA_W-1:0] d;
		logic one_byte;
		logic bad;
		vl_t vl;
		int n;
		r0 = '0;
		r1 = '0;
		bad = 1'b0;
		n = 0;
		if (t >= NUM_TRACKS)
			return 0;
		if (start)
			clear_track_ctx(t);
		d = trk_delta[t];
		case (trk_phase[t])
			PH_STATUS: begin
				if (c == ST_META) begin
					r0 = event_item(c, d, 1, 0, 0, t);
					trk_phase[t] = PH_META;
					n = 1;
				end else if (c == ST_SYSEX || c == ST_SYSEX_ESC) begin
					trk_rstat[t] = 8'h00;
					r0 = event_item(c, d, 1, 0, 0, t);
					trk_acc[t] = '0;
					trk_cnt[t] = 3'd0;
					trk_phase[t] = PH_LEN;
					n = 1;
				end else if (c[7]) begin
					if (c > ST_SYSEX) begin
						bad = 1'b1;
					end else begin
						trk_rstat[t] = c;
						trk_rem[t] = has_one_data_byte(c) ? 28'd1 : 28'd2;
						r0 = event_item(c, d, 1, 0, 0, t);
						trk_phase[t] = PH_DATA;
						n = 1;
					end
				end else if (trk_rstat[t][7]) begin
					one_byte = has_one_data_byte(trk_rstat[t]);
					r0 = event_item(trk_rstat[t], d, 1, 0, 0, t);
					r1 = event_item(c, d, 0, one_byte, 0, t);
					trk_rem[t] = one_byte ? 28'd0 : 28'd1;
					trk_phase[t] = one_byte ? PH_DELTA : PH_DATA;
					if (one_byte) begin
						trk_acc[t] = '0;
						trk_cnt[t] = 3'd0;
					end
					n = 2;
				end else begin
					bad = 1'b1;
				end
			end
			PH_META: begin
				r0 = event_item(c, d, 0, 0, 0, t);
				trk_acc[t] = '0;
				trk_cnt[t] = 3'd0;
				trk_phase[t] = PH_LEN;
				n = 1;
			end
			PH_LEN: begin
				vl = shift_in_varlen(t, c);
				if (vl == VL_OVER) begin
					bad = 1'b1;
				end else if (vl == VL_MORE) begin
					r0 = event_item(c, d, 0, 0, 0, t);
					n = 1;
				end else begin
					trk_rem[t] = trk_acc[t];
					trk_acc[t] = '0;
					trk_cnt[t] = 3'd0;
					r0 = event_item(c, d, 0, trk_rem[t] == '0, 0, t);
					trk_phase[t] = (trk_rem[t] == '0) ? PH_DELTA : PH_DATA;
					n = 1;
				end
			end
			PH_DATA: begin
				trk_rem[t] = trk_rem[t] - 28'd1;
				r0 = event_item(c, d, 0, trk_rem[t] == '0, 0, t);
				if (trk_rem[t] == '0) begin
					trk_phase[t] = PH_DELTA;
					trk_acc[t] = '0;
					trk_cnt[t] = 3'd0;
				end
				n = 1;
			end
			default: begin
				vl = shift_in_varlen(t, c);
				if (vl == VL_OVER) begin
					bad = 1'b1;
				end else if (vl == VL_DONE) begin
					trk_delta[t] = trk_acc[t];
					trk_acc[t] = '0;
					trk_cnt[t] = 3'd0;
					trk_phase[t] = PH_STATUS;
				end else begin
					trk_phase[t] = PH_DELTA;
				end
			end
		endcase
		if (bad) begin
			r0 = event_item(c, d, 1, 1, 1, t);
			trk_phase[t] = PH_DELTA;
			trk_acc[t] = '0;
			trk_cnt[t] = 3'd0;
			trk_rem[t] = '0;
			n = 1;
		end
		return n;
	endfunction

	function automatic void script_put(input int t, input logic [7:0] b);
		script_mem[t][script_len[t]] = {next_start, b};
		script_len[t]++;
		next_start = 1'b0;
	endfunction

	function automatic void script_varlen(input int t, input logic [DELTA_W-1:0] v,
			input int nb);
		for (int i = nb - 1; i >= 0; i--)
			script_put(t, {i != 0, 7'(v >> (7 * i))});
	endfunction

	// Length of a meta or sysex event, sometimes padded to more bytes, then its payload.
	function automatic void plan_payload(input int t);
		int len;
		int nb;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 6);
		nb = ($urandom_range(0, 9) < 7) ? 1 : $urandom_range(2, 4);
		script_varlen(t, DELTA_W'(len), nb);
		repeat (len) script_put(t, 8'($urandom_range(0, 255)));
	endfunction

	// Lay out the next stretch of bytes of one track: mostly a delta time and one
	// well-formed event, sometimes noise or a deliberately broken sequence.
	function automatic void plan_track_event(input int t);
		int pick;
		int nb;
		logic [DELTA_W-1:0] v;
		logic [7:0] s;
		script_len[t] = 0;
		script_rd[t] = 0;
		next_start = !track_seen[t] || ($urandom_range(0, 31) == 0);
		track_seen[t] = 1'b1;
		if (next_start)
			gen_rstat[t] = 8'h00;
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			repeat (4) script_put(t, VL_CONT | 8'($urandom_range(0, DATA_MAX)));
			return;
		end
		if (pick < 10) begin
			next_start = next_start | ($urandom_range(0, 7) == 0);
			script_put(t, 8'($urandom_range(0, 255)));
			return;
		end
		nb = ($urandom_range(0, 9) < 7) ? 1 : $urandom_range(2, 4);
		v = DELTA_W'($urandom & ((32'd1 << (7 * nb)) - 1));
		if ($urandom_range(0, 19) == 0)
			v = DELTA_W'((32'd1 << (7 * nb)) - 1);
		script_varlen(t, v, nb);
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			s = 8'($urandom_range(CHANNEL_LO, CHANNEL_HI));
			gen_rstat[t] = s;
			script_put(t, s);
			script_put(t, 8'($urandom_range(0, DATA_MAX)));
			if (!has_one_data_byte(s))
				script_put(t, 8'($urandom_range(0, DATA_MAX)));
			channel_planned++;
		end else if (pick < 60) begin
			script_put(t, 8'($urandom_range(0, DATA_MAX)));
			if (gen_rstat[t][7] && !has_one_data_byte(gen_rstat[t]))
				script_put(t, 8'($urandom_range(0, DATA_MAX)));
			running_planned++;
		end else if (pick < 72) begin
			script_put(t, ST_META);
			script_put(t, 8'($urandom_range(0, 255)));
			plan_payload(t);
			meta_planned++;
		end else if (pick < 82) begin
			script_put(t, $urandom_range(0, 1) ? ST_SYSEX : ST_SYSEX_ESC);
			gen_rstat[t] = 8'h00;
			plan_payload(t);
			sysex_planned++;
		end else if (pick < 90) begin
			s = 8'($urandom_range(BAD_STATUS_LO, BAD_STATUS_HI));
			script_put(t, (s == ST_SYSEX_ESC) ? BAD_STATUS_LO : s);
		end else begin
			// Meta or sysex length that never terminates.
			if ($urandom_range(0, 1)) begin
				script_put(t, ST_META);
				script_put(t, 8'($urandom_range(0, 255)));
			end else begin
				script_put(t, ST_SYSEX);
				gen_rstat[t] = 8'h00;
			end
			repeat (4) script_put(t, VL_CONT | 8'($urandom_range(0, DATA_MAX)));
		end
	endfunction

	// Offer one byte, wait for its transaction, then queue what it should produce.
	task automatic send_track_byte(input stim_row_t r);
		out_item_t p0;
		out_item_t p1;
		int n;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid <= 1'b1;
		track_index <= r.trk;
		data_byte <= r.b;
		track_start <= r.start;
		do @(posedge clk); while (!in_ready);
		n = parse_track_byte(int'(r.trk), r.b, r.start, p0, p1);
		case (r.kind)
			ROW_CHECKED: begin
				if (n > 0)
					expect_result(p0);
				if (n > 1)
					expect_result(p1);
			end
			ROW_TYPED: begin
				expect_result(event_item(r.want_byte, r.want_delta,
					r.want_first, r.want_last, r.want_err, int'(r.trk)));
			end
			default: begin
			end
		endcase
		bytes_sent++;
	endtask

	initial begin : stimulus
		stim_row_t r;
		int cur_trk;
		for (int t = 0; t < NUM_TRACKS; t++) begin
			clear_track_ctx(t);
			script_len[t] = 0;
			script_rd[t] = 0;
			gen_rstat[t] = 8'h00;
			track_seen[t] = 1'b0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_track_byte(directed_rows[i]);

		// Random part: tracks interleave, with a bias to stay on the same track so
		// that back-to-back bytes of one context come up often.
		cur_trk = 0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if ($urandom_range(0, 1))
				cur_trk = $urandom_range(0, NUM_TRACKS - 1);
			if (script_rd[cur_trk] >= script_len[cur_trk])
				plan_track_event(cur_trk);
			r = '0;
			r.kind = ROW_CHECKED;
			r.trk = cur_trk[TRACK_W-1:0];
			{r.start, r.b} = script_mem[cur_trk][script_rd[cur_trk]];
			script_rd[cur_trk]++;
			if (i == DRAIN_AT) begin
				// Let the block run dry before the next transaction.
				in_valid <= 1'b0;
				do @(posedge clk); while (pending_event_bytes.size() != 0);
				burst_left = 0;
				drain_pauses++;
			end
			send_track_byte(r);
			random_sent++;
		end

		in_valid <= 1'b0;
		while (pending_event_bytes.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d track bytes over %0d tracks;", bytes_sent, NUM_TRACKS,
			" checked %0d output bytes, %0d events, %0d errors.",
			results_seen, events_seen, errors_seen);
		$display("Planned %0d channel, %0d running-status, %0d meta, %0d sysex events;",
			channel_planned, running_planned, meta_planned, sysex_planned,
			" %0d long holds, %0d drains.", long_holds, drain_pauses);
		if (failure_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// The receiver runs its own stall pattern, changing mode every so often, and
	// once holds off for a long stretch so the block backs up into its input.
	initial begin : receiver
		int mode;
		int span;
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 4);
			span = $urandom_range(16, 200);
			for (int k = 0; k < span; k++) begin
				@(posedge clk);
				if (!held && random_sent >= HOLD_AT) begin
					out_ready <= 1'b0;
					repeat (LONG_HOLD) @(posedge clk);
					held = 1'b1;
					long_holds++;
				end else begin
					case (mode)
						0: out_ready <= 1'b1;
						1: out_ready <= 1'($urandom_range(0, 1));
						2: out_ready <= ($urandom_range(0, 3) == 0);
						3: out_ready <= (k % 3) != 0;
						default: out_ready <= (k % 16) < 8;
					endcase
				end
			end
		end
	end

	// Each output transaction is compared with the oldest queued expectation.
	always @(posedge clk) begin : result_check
		out_item_t seen;
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			seen = event_item(event_byte, delta_ticks, first_of_event, last_of_event,
				parse_error, int'(event_track));
			results_seen++;
			if (first_of_event && !parse_error)
				events_seen++;
			if (parse_error)
				errors_seen++;
			if (pending_event_bytes.size() == 0) begin
				failure_count++;
				if (failure_count <= MAX_REPORTS)
					$display("%0t: unexpected output byte %02h delta %0d", $time,
						seen.data, seen.delta,
						" first %b last %b err %b track %0d",
						seen.first, seen.last, seen.err, seen.track);
			end else begin
				want = pending_event_bytes.pop_front();
				if (seen.data !== want.data || seen.delta !== want.delta ||
						seen.first !== want.first || seen.last !== want.last ||
						seen.err !== want.err || seen.track !== want.track) begin
					failure_count++;
					if (failure_count <= MAX_REPORTS)
						$display("%0t: expected byte %02h delta %0d", $time,
							want.data, want.delta,
							" first %b last %b err %b track %0d,",
							want.first, want.last, want.err, want.track,
							" got byte %02h delta %0d", seen.data, seen.delta,
							" first %b last %b err %b track %0d",
							seen.first, seen.last, seen.err, seen.track);
				end
			end
		end
	end

	// Watchdog on cycles in which neither channel completes a transaction.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

// ===== midi_track_event_parser_core.f =====
rtl/mtep_pkg.sv
rtl/mtep_ctx_mem.sv
rtl/mtep_step.sv
rtl/mtep_out_fifo.sv
rtl/midi_track_event_parser_core.sv
rtl/mtep_checker.sv
sim/midi_track_event_parser_core_test.sv
